>>> sv/sktab_pkg.sv
// Package for the sorted key table: sizes, codes and the types shared by the cell row.
package sktab_pkg;

    localparam int TABLE_DEPTH  = 16;
    localparam int KEY_CHARS    = 8;
    localparam int PAYLOAD_BITS = 64;

    localparam int KEY_BITS = 8 * KEY_CHARS;
    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    // Width wide enough to compare a 4-bit position against the count.
    localparam int CMP_W    = (CNT_W > 4) ? CNT_W : 4;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_FIND   = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_UPDATE = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    // Command broadcast to every cell during the execute cycle.
    typedef struct packed {
        logic                    do_ins;
        logic                    do_find;
        logic                    do_del;
        logic                    do_upd;
        logic                    do_read;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [3:0]              pos;
        logic [CNT_W-1:0]        count;
    } sktab_cmd_t;

    // Chain and status flags that each cell passes on.
    typedef struct packed {
        logic sfx;     // every valid entry from this cell upward is greater than the key
        logic prior;   // an equal key was seen at or below this cell
        logic hit;     // this cell supplies the found or read entry
        logic wr_new;  // this cell takes the inserted entry
    } sktab_flags_t;

endpackage

>>> sv/sorted_key_table_top.sv
// Top level of the sorted key table: request register, cell row and result register.
//
//  channel   | beat marked by        | ports
//  ----------+-----------------------+--------------------------------------------------
//  request   | start && !busy        | op, key, payload, position
//  result    | done (one cycle)      | status, found_position, out_key, out_payload,
//            |                       | entry_count
//
// The accept edge loads the request register; in the execute cycle the whole cell row runs
// at once (compare, shift, write) and the result register is loaded.
// busy is high for the one execute cycle; done is high in the cycle after it.
// Reset clears the entry count; the entries themselves are not reset.
// The result is shown for a single cycle and the receiver cannot stall it.
module sorted_key_table_top
    import sktab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [63:0] key,
    input  logic [63:0] payload,
    input  logic [3:0]  position,
    output logic        done,
    output logic [1:0]  status,
    output logic [3:0]  found_position,
    output logic [63:0] out_key,
    output logic [63:0] out_payload,
    output logic [4:0]  entry_count
);

    logic                    exec_reg;
    logic                    done_reg;
    logic [2:0]              op_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [3:0]              pos_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [1:0]              status_reg;
    logic [1:0]              status_next;
    logic [3:0]              fpos_reg;
    logic [63:0]             okey_reg;
    logic [63:0]             opay_reg;

    sktab_cmd_t              cmd;
    logic                    full;
    logic                    pos_ok;
    logic                    any_hit;
    logic [IDX_W-1:0]        sel_idx;
    logic [KEY_BITS-1:0]     sel_key;
    logic [PAYLOAD_BITS-1:0] sel_payload;

    logic [KEY_BITS-1:0]     cell_key     [TABLE_DEPTH];
    logic [PAYLOAD_BITS-1:0] cell_payload [TABLE_DEPTH];
    sktab_flags_t            flags        [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  hit_vec;
    logic [TABLE_DEPTH-1:0]  wr_vec;

    assign busy   = exec_reg;
    assign full   = count_reg == CNT_W'(TABLE_DEPTH);
    assign pos_ok = CMP_W'(pos_reg) < CMP_W'(count_reg);

    always_comb
    begin
        cmd.do_ins  = exec_reg && (op_reg == OP_INSERT) && !full;
        cmd.do_find = exec_reg && (op_reg == OP_FIND);
        cmd.do_del  = exec_reg && (op_reg == OP_DELETE) && pos_ok;
        cmd.do_upd  = exec_reg && (op_reg == OP_UPDATE) && pos_ok;
        cmd.do_read = exec_reg && (op_reg == OP_READ) && pos_ok;
        cmd.key     = key_reg;
        cmd.payload = payload_reg;
        cmd.pos     = pos_reg;
        cmd.count   = count_reg;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            logic                    sfx_in;
            logic                    sfx_dn;
            logic                    prior_in;
            logic [KEY_BITS-1:0]     lo_key;
            logic [PAYLOAD_BITS-1:0] lo_payload;
            logic [KEY_BITS-1:0]     up_key;
            logic [PAYLOAD_BITS-1:0] up_payload;

            if (g == 0)
            begin : g_bottom
                assign sfx_dn     = 1'b0;
                assign prior_in   = 1'b0;
                assign lo_key     = '0;
                assign lo_payload = '0;
            end
            else
            begin : g_lower
                assign sfx_dn     = flags[g-1].sfx;
                assign prior_in   = flags[g-1].prior;
                assign lo_key     = cell_key[g-1];
                assign lo_payload = cell_payload[g-1];
            end

            if (g == TABLE_DEPTH - 1)
            begin : g_top
                assign sfx_in     = 1'b1;
                assign up_key     = cell_key[g];
                assign up_payload = cell_payload[g];
            end
            else
            begin : g_upper
                assign sfx_in     = flags[g+1].sfx;
                assign up_key     = cell_key[g+1];
                assign up_payload = cell_payload[g+1];
            end

            sktab_cell u_cell (
                .clk          (clk),
                .idx          (IDX_W'(g)),
                .cmd          (cmd),
                .sfx_in       (sfx_in),
                .sfx_dn       (sfx_dn),
                .prior_in     (prior_in),
                .lo_key       (lo_key),
                .lo_payload   (lo_payload),
                .up_key       (up_key),
                .up_payload   (up_payload),
                .cell_key     (cell_key[g]),
                .cell_payload (cell_payload[g]),
                .flags        (flags[g])
            );

            assign hit_vec[g] = flags[g].hit;
            assign wr_vec[g]  = flags[g].wr_new;
        end
    endgenerate

    // At most one cell hits and at most one takes a new entry, so OR-ing selects.
    always_comb
    begin
        sel_idx     = '0;
        sel_key     = '0;
        sel_payload = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (flags[i].hit || flags[i].wr_new)
            begin
                sel_idx = sel_idx | IDX_W'(i);
            end
            if (flags[i].hit)
            begin
                sel_key     = sel_key | cell_key[i];
                sel_payload = sel_payload | cell_payload[i];
            end
        end
    end

    assign any_hit = |hit_vec;

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        case (op_reg)
            OP_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_FIND:
            begin
                if (!any_hit)
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            OP_DELETE:
            begin
                if (!pos_ok)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_UPDATE, OP_READ:
            begin
                if (!pos_ok)
                begin
                    status_next = ST_RANGE;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= exec_reg;
            if (exec_reg)
            begin
                exec_reg  <= 1'b0;
                count_reg <= count_next;
            end
            else if (start)
            begin
                exec_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !exec_reg)
        begin
            op_reg      <= op;
            key_reg     <= key[KEY_BITS-1:0];
            payload_reg <= payload[PAYLOAD_BITS-1:0];
            pos_reg     <= position;
        end
        if (exec_reg)
        begin
            status_reg <= status_next;
            fpos_reg   <= 4'(sel_idx);
            okey_reg   <= 64'(sel_key);
            opay_reg   <= 64'(sel_payload);
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign found_position = fpos_reg;
    assign out_key        = okey_reg;
    assign out_payload    = opay_reg;
    assign entry_count    = 5'(count_reg);

`ifndef ASSERT_OFF
    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        exec_reg |=> (done_reg && !exec_reg))
        else $error("execute cycle did not end in a result beat");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec) && $onehot0(wr_vec))
        else $error("more than one cell selected");

    a_insert_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_ins |-> $onehot(wr_vec))
        else $error("insert without exactly one target cell");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_reg |=> $stable(count_reg))
        else $error("entry count changed outside an execute cycle");
`endif

endmodule

>>> sv/sktab_cell.sv
// One entry of the sorted key table: holds a key and payload and shifts with its neighbors.
module sktab_cell
    import sktab_pkg::*;
(
    input  logic                    clk,
    input  logic [IDX_W-1:0]        idx,
    input  sktab_cmd_t              cmd,
    input  logic                    sfx_in,
    input  logic                    sfx_dn,
    input  logic                    prior_in,
    input  logic [KEY_BITS-1:0]     lo_key,
    input  logic [PAYLOAD_BITS-1:0] lo_payload,
    input  logic [KEY_BITS-1:0]     up_key,
    input  logic [PAYLOAD_BITS-1:0] up_payload,
    output logic [KEY_BITS-1:0]     cell_key,
    output logic [PAYLOAD_BITS-1:0] cell_payload,
    output sktab_flags_t            flags
);

    logic [KEY_BITS-1:0]     key_reg;
    logic [KEY_BITS-1:0]     key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [PAYLOAD_BITS-1:0] payload_next;
    logic                    valid;
    logic                    eq;
    logic                    at_pos;
    logic                    from_pos;
    logic                    shift_up;

    assign valid    = CNT_W'(idx) < cmd.count;
    assign eq       = valid && (key_reg == cmd.key);
    assign at_pos   = CMP_W'(idx) == CMP_W'(cmd.pos);
    assign from_pos = CMP_W'(idx) >= CMP_W'(cmd.pos);

    assign flags.sfx    = sfx_in && (!valid || (key_reg > cmd.key));
    assign flags.prior  = prior_in || eq;
    assign flags.hit    = (cmd.do_find && eq && !prior_in) || (cmd.do_read && at_pos);
    // The insert slot is the lowest cell whose upper run is all greater.
    assign flags.wr_new = cmd.do_ins && flags.sfx && !sfx_dn;
    assign shift_up     = cmd.do_ins && flags.sfx && sfx_dn;

    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (shift_up)
        begin
            key_next     = lo_key;
            payload_next = lo_payload;
        end
        else if (flags.wr_new || (cmd.do_upd && at_pos))
        begin
            key_next     = cmd.key;
            payload_next = cmd.payload;
        end
        else if (cmd.do_del && from_pos)
        begin
            key_next     = up_key;
            payload_next = up_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign cell_key     = key_reg;
    assign cell_payload = payload_reg;

endmodule

>>> sim/sorted_key_table_checker.sv
// Checker for the sorted key table: tracks the table contents, predicts each result and compares.
`timescale 1ns / 100ps

module sorted_key_table_checker
    import sktab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  op,
    input  logic [63:0] key,
    input  logic [63:0] payload,
    input  logic [3:0]  position,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [3:0]  found_position,
    input  logic [63:0] out_key,
    input  logic [63:0] out_payload,
    input  logic [4:0]  entry_count,
    output int          mismatches,
    output int          outstanding,
    output logic [4:0]  table_fill
);

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  found_position;
        logic [63:0] out_key;
        logic [63:0] out_payload;
        logic [4:0]  entry_count;
    } table_result_t;

    logic [KEY_BITS-1:0]     shadow_keys [TABLE_DEPTH];
    logic [PAYLOAD_BITS-1:0] shadow_payloads [TABLE_DEPTH];
    int                      shadow_fill;
    table_result_t           pending_results [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        table_fill  = '0;
        shadow_fill = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            shadow_keys[i]     = '0;
            shadow_payloads[i] = '0;
        end
    end

    // Applies one request to the shadow table and returns the result it must produce.
    task automatic apply_request(
        input  logic [2:0]  req_op,
        input  logic [63:0] req_key,
        input  logic [63:0] req_payload,
        input  logic [3:0]  req_pos,
        output table_result_t res
    );
        int   i;
        logic hit;
        res        = '0;
        res.status = ST_OK;
        hit        = 1'b0;
        case (req_op)
            OP_INSERT:
            begin
                if (shadow_fill >= TABLE_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    // Walk down past strictly greater keys, so equal keys keep arrival order.
                    i = shadow_fill;
                    while (i > 0 && shadow_keys[i-1] > req_key[KEY_BITS-1:0])
                    begin
                        shadow_keys[i]     = shadow_keys[i-1];
                        shadow_payloads[i] = shadow_payloads[i-1];
                        i--;
                    end
                    shadow_keys[i]     = req_key[KEY_BITS-1:0];
                    shadow_payloads[i] = req_payload[PAYLOAD_BITS-1:0];
                    shadow_fill++;
                    res.found_position = i[3:0];
                end
            end
            OP_FIND:
            begin
                res.status = ST_NOT_FOUND;
                for (i = 0; i < shadow_fill; i++)
                begin
                    if (!hit && shadow_keys[i] == req_key[KEY_BITS-1:0])
                    begin
                        hit                = 1'b1;
                        res.status         = ST_OK;
                        res.found_position = i[3:0];
                        res.out_key        = 64'(shadow_keys[i]);
                        res.out_payload    = 64'(shadow_payloads[i]);
                    end
                end
            end
            OP_DELETE, OP_UPDATE, OP_READ:
            begin
                if (int'(req_pos) >= shadow_fill)
                    res.status = ST_RANGE;
                else if (req_op == OP_DELETE)
                begin
                    for (i = int'(req_pos); i + 1 < shadow_fill; i++)
                    begin
                        shadow_keys[i]     = shadow_keys[i+1];
                        shadow_payloads[i] = shadow_payloads[i+1];
                    end
                    shadow_fill--;
                end
                else if (req_op == OP_UPDATE)
                begin
                    shadow_keys[req_pos]     = req_key[KEY_BITS-1:0];
                    shadow_payloads[req_pos] = req_payload[PAYLOAD_BITS-1:0];
                end
                else
                begin
                    res.found_position = req_pos;
                    res.out_key        = 64'(shadow_keys[req_pos]);
                    res.out_payload    = 64'(shadow_payloads[req_pos]);
                end
            end
            default:
            begin
            end
        endcase
        res.entry_count = shadow_fill[4:0];
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        table_result_t want;
        if (rst_n)
        begin
            // Retire the finished beat before queuing a new one accepted at the same edge.
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", 64'(want.status), 64'(status));
                    check_field("found_position", 64'(want.found_position), 64'(found_position));
                    check_field("out_key", want.out_key, out_key);
                    check_field("out_payload", want.out_payload, out_payload);
                    check_field("entry_count", 64'(want.entry_count), 64'(entry_count));
                end
            end
            if (start && !busy)
            begin
                apply_request(op, key, payload, position, want);
                pending_results.push_back(want);
            end
            outstanding <= pending_results.size();
            table_fill  <= shadow_fill[4:0];
        end
    end

endmodule

>>> sim/sorted_key_table_top_test.sv
// Testbench top for the sorted key table: clock, reset, request stimulus and the verdict.
`timescale 1ns / 100ps

module sorted_key_table_top_test;
    import sktab_pkg::*;

    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
    localparam int         RANDOM_ITEMS    = 1550;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  op = OP_INSERT;
    logic [63:0] key = '0;
    logic [63:0] payload = '0;
    logic [3:0]  position = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [3:0]  found_position;
    logic [63:0] out_key;
    logic [63:0] out_payload;
    logic [4:0]  entry_count;
    int          mismatches;
    int          outstanding;
    logic [4:0]  table_fill;

    logic [63:0] key_pool [8];
    int          burst_left;

    always #5 clk = ~clk;

    sorted_key_table_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .key            (key),
        .payload        (payload),
        .position       (position),
        .done           (done),
        .status         (status),
        .found_position (found_position),
        .out_key        (out_key),
        .out_payload    (out_payload),
        .entry_count    (entry_count)
    );

    sorted_key_table_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .key            (key),
        .payload        (payload),
        .position       (position),
        .done           (done),
        .status         (status),
        .found_position (found_position),
        .out_key        (out_key),
        .out_payload    (out_payload),
        .entry_count    (entry_count),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .table_fill     (table_fill)
    );

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // A printable name of one to eight characters, zero padded, first character in the top byte.
    function automatic logic [63:0] rand_name();
        logic [63:0] name;
        int          len;
        name = '0;
        len  = $urandom_range(1, 8);
        for (int c = 0; c < len; c++)
            name[63 - 8*c -: 8] = 8'($urandom_range(8'h20, 8'h7e));
        return name;
    endfunction

    // Pool keys repeat often, so duplicates and find hits are common.
    function automatic logic [63:0] rand_key();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return key_pool[$urandom_range(0, 7)];
        else if (pick < 80)
            return rand_name();
        else
            return rand_word();
    endfunction

    task automatic send_request(
        input logic [2:0]  req_op,
        input logic [63:0] req_key,
        input logic [63:0] req_payload,
        input logic [3:0]  req_pos
    );
        start    <= 1'b1;
        op       <= req_op;
        key      <= req_key;
        payload  <= req_payload;
        position <= req_pos;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // The beat was taken at this edge; either keep start high or open a gap.
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int          sel;
        int          fill_now;
        logic        growing;
        logic [2:0]  rop;
        logic [3:0]  rpos;

        burst_left  = 4;
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = {"ALPHA", 24'h0};
        key_pool[3] = {"BETA", 32'h0};
        for (int i = 4; i < 8; i++)
            key_pool[i] = rand_name();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: every access is out of range, a find misses.
        send_request(OP_READ, '0, '0, 4'd0);
        send_request(OP_FIND, '0, '0, 4'd0);
        send_request(OP_DELETE, '0, '0, 4'd15);
        // Extremes of key and payload, then an equal key that must land after the first.
        send_request(OP_INSERT, '1, '1, 4'd0);
        send_request(OP_INSERT, '0, '0, 4'd0);
        send_request(OP_INSERT, key_pool[2], 64'h1111_2222_3333_4444, 4'd0);
        send_request(OP_INSERT, key_pool[2], 64'h5555_6666_7777_8888, 4'd0);
        send_request(OP_FIND, key_pool[2], '0, 4'd0);
        // An update writes in place even where it breaks the order.
        send_request(OP_UPDATE, 64'h1, 64'haaaa_aaaa_aaaa_aaaa, 4'd3);
        send_request(OP_READ, '0, '0, 4'd3);
        send_request(OP_READ, '0, '0, 4'd4);
        for (int u = OP_FIRST_UNUSED; u <= OP_LAST_UNUSED; u++)
            send_request(3'(u), '1, '1, 4'd15);
        send_request(OP_DELETE, '0, '0, 4'd0);
        // Fill to capacity, then probe the top position and the full case.
        for (int i = 0; i < TABLE_DEPTH - 3; i++)
            send_request(OP_INSERT, rand_key(), rand_word(), 4'($urandom));
        send_request(OP_INSERT, rand_key(), rand_word(), 4'd0);
        send_request(OP_READ, '0, '0, 4'd15);
        send_request(OP_DELETE, '0, '0, 4'd15);
        send_request(OP_UPDATE, rand_word(), rand_word(), 4'd15);
        send_request(OP_FIND, 64'h0102_0304_0506_0708, '0, 4'd0);

        growing = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            fill_now = int'(table_fill);
            if (growing && fill_now == TABLE_DEPTH && $urandom_range(0, 3) == 0)
                growing = 1'b0;
            else if (!growing && fill_now == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 99) < 3)
                growing = ~growing;

            sel = $urandom_range(0, 99);
            if (sel < 2)
                rop = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
            else if (sel < (growing ? 47 : 17))
                rop = OP_INSERT;
            else if (sel < (growing ? 67 : 37))
                rop = OP_FIND;
            else if (sel < (growing ? 77 : 77))
                rop = growing ? OP_DELETE : OP_DELETE;
            else if (sel < 87)
                rop = OP_UPDATE;
            else
                rop = OP_READ;
            // In the shrinking phase the delete band above covers 37..76.
            if (!growing && sel >= 37 && sel < 77)
                rop = OP_DELETE;
            else if (growing && sel >= 67 && sel < 77)
                rop = OP_DELETE;

            if (fill_now > 0 && $urandom_range(0, 99) < 85)
                rpos = 4'($urandom_range(0, fill_now - 1));
            else
                rpos = 4'($urandom);

            send_request(rop, rand_key(), rand_word(), rpos);
        end
        start <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
